### src/sbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

	localparam int GROUP_W       = 11;
	localparam int COORD_W       = 32;
	localparam int COUNT_W       = 32;
	localparam int SUM_W         = 42;
	localparam int SCALE_W       = 17;
	localparam int SCALE_SUM_W   = 27;
	localparam int MAX_GROUP_DEF = 1024;
	localparam int QUEUE_DEPTH   = 2;

	// result kinds
	localparam logic KIND_BIN  = 1'b0;
	localparam logic KIND_MARK = 1'b1;

	// one unit of work handed from the front end to the back end
	typedef struct packed {
		logic                   has_bin;
		logic                   has_mark;
		logic [COORD_W-1:0]     first_start;
		logic [COORD_W-1:0]     last_end;
		logic [SUM_W-1:0]       sum_a;
		logic [SUM_W-1:0]       sum_b;
		logic [SCALE_SUM_W-1:0] scale_sum;
		logic [GROUP_W-1:0]     divisor;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_BIN,
		B_MARK
	} back_state_t;

endpackage

`default_nettype wire

### src/sbm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sbm_front #(
	parameter int MAX_GROUP = sbm_pkg::MAX_GROUP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [sbm_pkg::GROUP_W-1:0]     cfg_wr_data,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [sbm_pkg::COORD_W-1:0]     bin_start,
	input  wire logic [sbm_pkg::COORD_W-1:0]     bin_end,
	input  wire logic [sbm_pkg::COUNT_W-1:0]     read_count_a,
	input  wire logic [sbm_pkg::COUNT_W-1:0]     read_count_b,
	input  wire logic [sbm_pkg::SCALE_W-1:0]     nondead_scale,
	input  wire logic                            segment_last,
	input  wire logic                            q_full,
	output      logic                            q_push,
	output      sbm_pkg::job_t                   q_job
);

	logic [sbm_pkg::GROUP_W-1:0]     size_q;
	logic [sbm_pkg::GROUP_W-1:0]     fill_q;
	logic [sbm_pkg::COORD_W-1:0]     first_q;
	logic [sbm_pkg::SUM_W-1:0]       acc_a_q;
	logic [sbm_pkg::SUM_W-1:0]       acc_b_q;
	logic [sbm_pkg::SCALE_SUM_W-1:0] acc_scale_q;

	logic [sbm_pkg::GROUP_W-1:0]     size_eff;
	logic [sbm_pkg::GROUP_W-1:0]     fill_next;
	logic [sbm_pkg::COORD_W-1:0]     first_next;
	logic [sbm_pkg::SUM_W-1:0]       acc_a_next;
	logic [sbm_pkg::SUM_W-1:0]       acc_b_next;
	logic [sbm_pkg::SCALE_SUM_W-1:0] acc_scale_next;
	logic                            group_done;
	logic                            accept;

	// zero acts as one, large values clip to the configured maximum
	always_comb begin
		size_eff = (cfg_wr_data == '0) ? sbm_pkg::GROUP_W'(1) : cfg_wr_data;
		if (32'(size_eff) > 32'(MAX_GROUP)) begin
			size_eff = sbm_pkg::GROUP_W'(MAX_GROUP);
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		fill_next      = fill_q + sbm_pkg::GROUP_W'(1);
		first_next     = (fill_q == '0) ? bin_start : first_q;
		acc_a_next     = acc_a_q + sbm_pkg::SUM_W'(read_count_a);
		acc_b_next     = acc_b_q + sbm_pkg::SUM_W'(read_count_b);
		acc_scale_next = acc_scale_q + sbm_pkg::SCALE_SUM_W'(nondead_scale);
		group_done     = (fill_next >= size_q);

		q_job.has_bin     = group_done;
		q_job.has_mark    = segment_last;
		q_job.first_start = first_next;
		q_job.last_end    = bin_end;
		q_job.sum_a       = acc_a_next;
		q_job.sum_b       = acc_b_next;
		q_job.scale_sum   = acc_scale_next;
		q_job.divisor     = size_q;
		q_push            = accept && (group_done || segment_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= sbm_pkg::GROUP_W'(1);
			fill_q      <= '0;
			first_q     <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			acc_scale_q <= '0;
		end else if (cfg_wr_en) begin
			// new size drops any partial group
			size_q      <= size_eff;
			fill_q      <= '0;
			first_q     <= '0;
			acc_a_q     <= '0;
			acc_b_q     <= '0;
			acc_scale_q <= '0;
		end else if (accept) begin
			if (group_done || segment_last) begin
				fill_q      <= '0;
				first_q     <= '0;
				acc_a_q     <= '0;
				acc_b_q     <= '0;
				acc_scale_q <= '0;
			end else begin
				fill_q      <= fill_next;
				first_q     <= first_next;
				acc_a_q     <= acc_a_next;
				acc_b_q     <= acc_b_next;
				acc_scale_q <= acc_scale_next;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q != '0) && (fill_q < size_q))
		else $error("group fill reached group size without closing the group");
`endif

endmodule

`default_nettype wire

### src/sbm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sbm_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sbm_pkg::job_t push_job,
	input  wire logic          pop,
	output      sbm_pkg::job_t pop_job,
	output      logic          full,
	output      logic          empty
);

	localparam int DEPTH = sbm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbm_pkg::job_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

### src/sbm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sbm_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_empty,
	input  wire sbm_pkg::job_t                   q_job,
	output      logic                            q_pop,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            kind,
	output      logic [sbm_pkg::COORD_W-1:0]     merged_start,
	output      logic [sbm_pkg::COORD_W-1:0]     merged_end,
	output      logic [sbm_pkg::SUM_W-1:0]       sum_a,
	output      logic [sbm_pkg::SUM_W-1:0]       sum_b,
	output      logic [sbm_pkg::SCALE_W-1:0]     mean_scale
);

	localparam int DIV_STEPS = sbm_pkg::SCALE_SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int DW        = sbm_pkg::GROUP_W;

	sbm_pkg::back_state_t            state_q;
	sbm_pkg::back_state_t            state_next;
	sbm_pkg::job_t                   job_q;
	logic [DW-1:0]                   rem_q;
	logic [sbm_pkg::SCALE_SUM_W-1:0] quot_q;
	logic [STEP_W-1:0]               step_q;

	logic [DW:0]                     trial;
	logic [DW:0]                     diff;
	logic                            trial_ge;
	logic [DW-1:0]                   rem_next;
	logic                            last_step;
	logic                            out_take;

	// one restoring divide step per cycle
	always_comb begin
		trial     = {rem_q, quot_q[sbm_pkg::SCALE_SUM_W-1]};
		diff      = trial - {1'b0, job_q.divisor};
		trial_ge  = (trial >= {1'b0, job_q.divisor});
		rem_next  = trial_ge ? diff[DW-1:0] : trial[DW-1:0];
		last_step = (step_q == STEP_W'(DIV_STEPS - 1));
	end

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbm_pkg::B_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next   = state_q;
		q_pop        = 1'b0;
		out_valid    = 1'b0;
		kind         = sbm_pkg::KIND_BIN;
		merged_start = '0;
		merged_end   = '0;
		sum_a        = '0;
		sum_b        = '0;
		mean_scale   = '0;
		unique case (state_q)
			sbm_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (!q_job.has_bin) begin
						state_next = sbm_pkg::B_MARK;
					end else if (q_job.divisor == DW'(1)) begin
						state_next = sbm_pkg::B_BIN;
					end else begin
						state_next = sbm_pkg::B_DIV;
					end
				end
			end
			sbm_pkg::B_DIV: begin
				if (last_step) begin
					state_next = sbm_pkg::B_BIN;
				end
			end
			sbm_pkg::B_BIN: begin
				out_valid    = 1'b1;
				kind         = sbm_pkg::KIND_BIN;
				merged_start = job_q.first_start;
				merged_end   = job_q.last_end;
				sum_a        = job_q.sum_a;
				sum_b        = job_q.sum_b;
				mean_scale   = quot_q[sbm_pkg::SCALE_W-1:0];
				if (out_take) begin
					state_next = job_q.has_mark ? sbm_pkg::B_MARK : sbm_pkg::B_IDLE;
				end
			end
			sbm_pkg::B_MARK: begin
				out_valid = 1'b1;
				kind      = sbm_pkg::KIND_MARK;
				if (out_take) begin
					state_next = sbm_pkg::B_IDLE;
				end
			end
			default: begin
				state_next = sbm_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= q_job;
			rem_q  <= '0;
			step_q <= '0;
			quot_q <= q_job.scale_sum;
		end else if (state_q == sbm_pkg::B_DIV) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[sbm_pkg::SCALE_SUM_W-2:0], trial_ge};
			step_q <= step_q + STEP_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_div_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbm_pkg::B_DIV) |-> (step_q < STEP_W'(DIV_STEPS)))
		else $error("divide step counter ran past the last step");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbm_pkg::B_DIV) |-> (job_q.divisor > DW'(1)))
		else $error("divider started with a trivial divisor");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbm_pkg::B_BIN) |-> (rem_q < job_q.divisor))
		else $error("final remainder not below the group size");

	a_bin_job_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbm_pkg::B_BIN) |-> job_q.has_bin)
		else $error("merged bin shown for a marker-only job");
`endif

endmodule

`default_nettype wire

### src/segmented_bin_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// segmented_bin_merge: merges each run of group_size fine bins inside a segment into one
// coarse bin (start of the first bin, end of the last, summed read counts, truncated mean
// of the Q1.16 live fraction) and sends a marker after every segment end; a partial group
// at a segment end is dropped. A front end takes one bin per cycle, while the queue has
// room, into 42-bit and 27-bit accumulators and hands finished work to a two-entry job
// queue; the back end computes the mean with a restoring divider that retires one
// quotient bit per cycle. A merged bin with group size 1 goes from the queue pop straight
// to output; any other merged bin passes through queue pop, 27 divide steps and output. A
// segment marker follows the merged bin of the same transfer, or comes on its own after a
// queue pop. The queue lets the front end take new bins while the back end still divides.
// Writing group_size discards any partial group; zero counts as one and values above
// MAX_GROUP clip to MAX_GROUP.

module segmented_bin_merge #(
	parameter int MAX_GROUP = sbm_pkg::MAX_GROUP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	// group size register
	input  wire logic                            cfg_wr_en,
	input  wire logic [sbm_pkg::GROUP_W-1:0]     cfg_wr_data,

	// fine bin input
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [sbm_pkg::COORD_W-1:0]     bin_start,
	input  wire logic [sbm_pkg::COORD_W-1:0]     bin_end,
	input  wire logic [sbm_pkg::COUNT_W-1:0]     read_count_a,
	input  wire logic [sbm_pkg::COUNT_W-1:0]     read_count_b,
	input  wire logic [sbm_pkg::SCALE_W-1:0]     nondead_scale,
	input  wire logic                            segment_last,

	// merged bin and marker output
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            kind,
	output      logic [sbm_pkg::COORD_W-1:0]     merged_start,
	output      logic [sbm_pkg::COORD_W-1:0]     merged_end,
	output      logic [sbm_pkg::SUM_W-1:0]       sum_a,
	output      logic [sbm_pkg::SUM_W-1:0]       sum_b,
	output      logic [sbm_pkg::SCALE_W-1:0]     mean_scale
);

	// job hand-off between front and back end
	sbm_pkg::job_t push_job;
	sbm_pkg::job_t pop_job;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;

	// accumulation, closes a group or a segment per transfer
	sbm_front #(
		.MAX_GROUP (MAX_GROUP)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bin_start     (bin_start),
		.bin_end       (bin_end),
		.read_count_a  (read_count_a),
		.read_count_b  (read_count_b),
		.nondead_scale (nondead_scale),
		.segment_last  (segment_last),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (push_job)
	);

	// short queue so each side can stall on its own
	sbm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// mean division and result sequencing
	sbm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.merged_start (merged_start),
		.merged_end   (merged_end),
		.sum_a        (sum_a),
		.sum_b        (sum_b),
		.mean_scale   (mean_scale)
	);

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

	import sbm_pkg::*;

	localparam int SETTLE_CYCLES  = 40;   // quiet time before a group size write
	localparam int TAIL_CYCLES    = 80;   // watch for stray results at the end
	localparam int WATCHDOG_LIMIT = 2000; // cycles without any transfer
	localparam int MAX_SHOWN      = 50;   // cap on printed mismatches

	typedef enum {OP_BIN, OP_CFG, OP_DRAIN} op_kind_t;

	// one fine bin as it enters the block
	typedef struct packed {
		logic [COORD_W-1:0] lo_coord;
		logic [COORD_W-1:0] hi_coord;
		logic [COUNT_W-1:0] cnt_a;
		logic [COUNT_W-1:0] cnt_b;
		logic [SCALE_W-1:0] scale;
		logic               last;
	} fine_t;

	// one coarse bin or segment marker as it leaves the block
	typedef struct packed {
		logic               is_mark;
		logic [COORD_W-1:0] lo_coord;
		logic [COORD_W-1:0] hi_coord;
		logic [SUM_W-1:0]   total_a;
		logic [SUM_W-1:0]   total_b;
		logic [SCALE_W-1:0] avg_scale;
	} coarse_t;

	// pending stimulus: a bin, a group size write, or a wait for the output to drain
	typedef struct {
		op_kind_t           kind;
		fine_t              bin;
		logic [GROUP_W-1:0] size;
	} op_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_wr_en     = 1'b0;
	logic [GROUP_W-1:0]   cfg_wr_data   = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [COORD_W-1:0]   bin_start     = '0;
	logic [COORD_W-1:0]   bin_end       = '0;
	logic [COUNT_W-1:0]   read_count_a  = '0;
	logic [COUNT_W-1:0]   read_count_b  = '0;
	logic [SCALE_W-1:0]   nondead_scale = '0;
	logic                 segment_last  = 1'b0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic                 kind;
	logic [COORD_W-1:0]   merged_start;
	logic [COORD_W-1:0]   merged_end;
	logic [SUM_W-1:0]     sum_a;
	logic [SUM_W-1:0]     sum_b;
	logic [SCALE_W-1:0]   mean_scale;

	op_t     bin_stream_q[$];  // stimulus not yet driven
	coarse_t coarse_q[$];      // coarse bins and markers still owed by the block

	// shadow of the block's grouping state
	logic [GROUP_W-1:0]     size_q;
	int                     fill_q;
	logic [COORD_W-1:0]     first_start_q;
	logic [SUM_W-1:0]       acc_a_q;
	logic [SUM_W-1:0]       acc_b_q;
	logic [SCALE_SUM_W-1:0] acc_scale_q;

	int  fail_cnt   = 0;
	int  settle_cnt = 0;
	int  quiet_cnt  = 0;
	int  bins_taken = 0;
	wire calm       = (bins_taken >= 300) && (bins_taken < 520);

	segmented_bin_merge i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bin_start     (bin_start),
		.bin_end       (bin_end),
		.read_count_a  (read_count_a),
		.read_count_b  (read_count_b),
		.nondead_scale (nondead_scale),
		.segment_last  (segment_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.merged_start  (merged_start),
		.merged_end    (merged_end),
		.sum_a         (sum_a),
		.sum_b         (sum_b),
		.mean_scale    (mean_scale)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// grouping predictor
	// ---------------------------------------------------------------

	function automatic void clear_group();
		fill_q        = 0;
		first_start_q = '0;
		acc_a_q       = '0;
		acc_b_q       = '0;
		acc_scale_q   = '0;
	endfunction

	function automatic void set_group_size(input logic [GROUP_W-1:0] v);
		size_q = v;
		clear_group();
	endfunction

	// fold one fine bin into the open group, queue whatever it completes
	function automatic void merge_bin(input fine_t b);
		int      n;
		coarse_t r;
		// zero acts as one, anything past the maximum clips
		if (size_q == 0)
			n = 1;
		else if (size_q > MAX_GROUP_DEF)
			n = MAX_GROUP_DEF;
		else
			n = size_q;
		if (fill_q == 0)
			first_start_q = b.lo_coord;
		acc_a_q     = acc_a_q + SUM_W'(b.cnt_a);
		acc_b_q     = acc_b_q + SUM_W'(b.cnt_b);
		acc_scale_q = acc_scale_q + SCALE_SUM_W'(b.scale);
		fill_q++;
		// a full group becomes one coarse bin
		if (fill_q >= n) begin
			r.is_mark   = KIND_BIN;
			r.lo_coord  = first_start_q;
			r.hi_coord  = b.hi_coord;
			r.total_a   = acc_a_q;
			r.total_b   = acc_b_q;
			r.avg_scale = SCALE_W'(acc_scale_q / SCALE_SUM_W'(n));
			coarse_q.insert(coarse_q.size(), r);
			clear_group();
		end
		// segment end: marker with zero payload, any partial group is lost
		if (b.last) begin
			r           = '0;
			r.is_mark   = KIND_MARK;
			coarse_q.insert(coarse_q.size(), r);
			clear_group();
		end
	endfunction

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(7))
			0: return '0;
			1: return 17'd65536;
			2: return 17'd65535;
			default: return SCALE_W'($urandom_range(65536));
		endcase
	endfunction

	task automatic add_bin(input logic [31:0] lo, hi, a, b, input logic [SCALE_W-1:0] sc,
			input logic lst);
		op_t op;
		op.kind = OP_BIN;
		op.bin  = '{lo_coord: lo, hi_coord: hi, cnt_a: a, cnt_b: b, scale: sc, last: lst};
		op.size = '0;
		bin_stream_q.insert(bin_stream_q.size(), op);
	endtask

	task automatic add_cfg(input logic [GROUP_W-1:0] v);
		op_t op;
		op.kind = OP_CFG;
		op.bin  = '0;
		op.size = v;
		bin_stream_q.insert(bin_stream_q.size(), op);
	endtask

	task automatic add_drain();
		op_t op;
		op.kind = OP_DRAIN;
		op.bin  = '0;
		op.size = '0;
		bin_stream_q.insert(bin_stream_q.size(), op);
	endtask

	// ---------------------------------------------------------------
	// input driver: takes ops from the stimulus queue, predicts on each transfer
	// ---------------------------------------------------------------

	always @(posedge clk) begin : drive_proc
		logic next_valid;
		logic next_cfg;
		op_t  op;
		if (arst_n) begin
			next_valid = in_valid;
			next_cfg   = 1'b0;
			if (in_valid && !in_stall) begin
				merge_bin('{lo_coord: bin_start, hi_coord: bin_end, cnt_a: read_count_a,
					cnt_b: read_count_b, scale: nondead_scale, last: segment_last});
				bins_taken <= bins_taken + 1;
				next_valid = 1'b0;
			end
			if (cfg_wr_en)
				set_group_size(cfg_wr_data);

			// register writes only after the block has gone quiet for a while
			if (coarse_q.size() != 0 || in_valid || cfg_wr_en)
				settle_cnt = 0;
			else if (settle_cnt < SETTLE_CYCLES)
				settle_cnt++;

			if (!next_valid && bin_stream_q.size() != 0) begin
				op = bin_stream_q[0];
				case (op.kind)
					OP_BIN: begin
						// random gaps, except in the calm stretch
						if (calm || $urandom_range(99) >= 38) begin
							bin_start     <= op.bin.lo_coord;
							bin_end       <= op.bin.hi_coord;
							read_count_a  <= op.bin.cnt_a;
							read_count_b  <= op.bin.cnt_b;
							nondead_scale <= op.bin.scale;
							segment_last  <= op.bin.last;
							next_valid    = 1'b1;
							void'(bin_stream_q.pop_front());
						end
					end
					OP_CFG: begin
						if (settle_cnt == SETTLE_CYCLES) begin
							cfg_wr_data <= op.size;
							next_cfg    = 1'b1;
							settle_cnt  = 0;
							void'(bin_stream_q.pop_front());
						end
					end
					OP_DRAIN: begin
						// hold the input until everything owed has come out
						if (coarse_q.size() == 0 && !in_valid)
							void'(bin_stream_q.pop_front());
					end
				endcase
			end
			in_valid  <= next_valid;
			cfg_wr_en <= next_cfg;
		end
	end

	// ---------------------------------------------------------------
	// output monitor: compares each transfer with the oldest owed result
	// ---------------------------------------------------------------

	task automatic check_field(input string what, input logic [SUM_W-1:0] want_v,
			input logic [SUM_W-1:0] got_v);
		if (want_v !== got_v) begin
			fail_cnt++;
			if (fail_cnt <= MAX_SHOWN)
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin : check_proc
		coarse_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (coarse_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= MAX_SHOWN)
					$display("%0t: unexpected result, expected none, actual kind %0b start %0h",
						$time, kind, merged_start);
			end else begin
				want = coarse_q.pop_front();
				check_field("kind", SUM_W'(want.is_mark), SUM_W'(kind));
				check_field("merged_start", SUM_W'(want.lo_coord), SUM_W'(merged_start));
				check_field("merged_end", SUM_W'(want.hi_coord), SUM_W'(merged_end));
				check_field("sum_a", want.total_a, sum_a);
				check_field("sum_b", want.total_b, sum_b);
				check_field("mean_scale", SUM_W'(want.avg_scale), SUM_W'(mean_scale));
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 38);
	end

	// ---------------------------------------------------------------
	// watchdog: no transfer of any kind for too long means a hang
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet_cnt <= 0;
			else
				quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cnt);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------

	initial begin : run_proc
		int                 k;
		int                 n;
		int                 pick;
		int                 seg_len;
		int                 rand_bins;
		logic [GROUP_W-1:0] size_w;

		set_group_size(GROUP_W'(1));

		// group size 1 after reset: every bin is its own coarse bin
		add_bin('1, '1, '1, '1, 17'd65536, 1'b0);
		add_bin('0, '0, '0, '0, '0, 1'b1);          // coarse bin then marker
		add_bin('0, '1, '1, '0, 17'h1FFFF, 1'b0);   // live fraction above one
		add_drain();

		// zero behaves as one
		add_cfg('0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b1);

		// groups of three: full group at segment end, partial groups dropped
		add_cfg(GROUP_W'(3));
		for (k = 0; k < 3; k++)
			add_bin(pick_word(), pick_word(), '1, '1, 17'd65536, k == 2);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b1);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b1);
		// open group left behind, discarded by the next write
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);

		add_cfg(GROUP_W'(2));
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b1);

		add_cfg(GROUP_W'(MAX_GROUP_DEF));
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b0);
		add_bin(pick_word(), pick_word(), pick_word(), pick_word(), pick_scale(), 1'b1);

		// register maximum clips to the largest group: a short segment only gives a marker
		add_cfg('1);
		for (k = 0; k < 16; k++)
			add_bin(pick_word(), pick_word(), '1, pick_word(), pick_scale(), k == 15);

		// random phases: mostly small groups, segments mostly whole groups
		rand_bins = 0;
		while (rand_bins < 915) begin
			pick = $urandom_range(99);
			if (pick < 6)
				size_w = '0;
			else if (pick < 14)
				size_w = GROUP_W'(1);
			else if (pick < 75)
				size_w = GROUP_W'($urandom_range(2, 6));
			else if (pick < 93)
				size_w = GROUP_W'($urandom_range(7, 24));
			else
				size_w = GROUP_W'($urandom_range(25, 64));
			add_cfg(size_w);
			n = (size_w == 0) ? 1 : int'(size_w);
			repeat ($urandom_range(1, 5)) begin
				seg_len = n * int'($urandom_range(0, (n > 16) ? 1 : 4));
				if (n > 1 && $urandom_range(3) == 0)
					seg_len += int'($urandom_range(1, n - 1));
				if (seg_len == 0)
					seg_len = 1;
				for (k = 0; k < seg_len; k++)
					add_bin(pick_word(), pick_word(), pick_word(), pick_word(),
						pick_scale(), k == seg_len - 1);
				rand_bins += seg_len;
				if ($urandom_range(7) == 0)
					add_drain();
			end
			// sometimes leave an open group for the next write to discard
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					add_bin(pick_word(), pick_word(), pick_word(), pick_word(),
						pick_scale(), 1'b0);
					rand_bins++;
				end
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (bin_stream_q.size() != 0 || in_valid || cfg_wr_en || coarse_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (coarse_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, coarse_q.size());
			fail_cnt += coarse_q.size();
		end
		if (fail_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
